/* design/cimask_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and the case fold for the pattern masker
// no dependencies
package cimask_pkg;

	localparam int CHAR_W      = 8;
	localparam int PATTERN_MAX = 16;
	localparam int IDX_W       = $clog2(PATTERN_MAX);
	localparam int FILL_W      = IDX_W + 1;
	localparam int DATA_W      = 64;
	localparam int REG_COUNT   = 4;
	localparam int REG_IDX_W   = $clog2(REG_COUNT);
	localparam int ADDR_W      = REG_IDX_W + 3;
	localparam int LEN_REG_W   = 5;

	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] MASK_RESET   = 8'h2A;

	localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_MASK_CHAR    = 2'd3;

	typedef struct packed {
		logic [PATTERN_MAX-1:0][CHAR_W-1:0] pattern;
		logic [FILL_W-1:0]                  length;
		logic [CHAR_W-1:0]                  mask;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic advance;
	} core_ctrl_t;

	typedef struct packed {
		logic              valid;
		logic [CHAR_W-1:0] data;
		logic              last;
	} emit_t;

	function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			r = c - CHAR_UPPER_A + CHAR_LOWER_A;
		end
		return r;
	endfunction

endpackage

/* design/cimask_cfg.sv */
`timescale 1ns / 1ps
// configuration registers behind an apb-style port
// depends on cimask_pkg
module cimask_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cimask_pkg::ADDR_W-1:0]       paddr,
	input  logic [cimask_pkg::DATA_W-1:0]       pwdata,
	output logic [cimask_pkg::DATA_W-1:0]       prdata,
	output logic                                pready,
	output cimask_pkg::cfg_t                    cfg
);

	logic [cimask_pkg::DATA_W-1:0]    pat_lo_q;
	logic [cimask_pkg::DATA_W-1:0]    pat_hi_q;
	logic [cimask_pkg::LEN_REG_W-1:0] len_q;
	logic [cimask_pkg::CHAR_W-1:0]    mask_q;
	logic [cimask_pkg::REG_IDX_W-1:0] reg_idx;
	logic                             wr_en;

	assign reg_idx = paddr[cimask_pkg::ADDR_W-1:3];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			len_q    <= '0;
			mask_q   <= cimask_pkg::MASK_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				cimask_pkg::REG_PATTERN_LOW:  pat_lo_q <= pwdata;
				cimask_pkg::REG_PATTERN_HIGH: pat_hi_q <= pwdata;
				cimask_pkg::REG_PATTERN_LEN:  len_q    <= pwdata[cimask_pkg::LEN_REG_W-1:0];
				cimask_pkg::REG_MASK_CHAR:    mask_q   <= pwdata[cimask_pkg::CHAR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			cimask_pkg::REG_PATTERN_LOW:  prdata = pat_lo_q;
			cimask_pkg::REG_PATTERN_HIGH: prdata = pat_hi_q;
			cimask_pkg::REG_PATTERN_LEN:
				prdata = cimask_pkg::DATA_W'(len_q);
			cimask_pkg::REG_MASK_CHAR:
				prdata = cimask_pkg::DATA_W'(mask_q);
			default: prdata = '0;
		endcase
	end

	// lengths past the window size clamp to the window size
	always_comb begin
		cfg.pattern = {pat_hi_q, pat_lo_q};
		cfg.mask    = mask_q;
		if (len_q > cimask_pkg::LEN_REG_W'(cimask_pkg::PATTERN_MAX)) begin
			cfg.length = cimask_pkg::FILL_W'(cimask_pkg::PATTERN_MAX);
		end else begin
			cfg.length = cimask_pkg::FILL_W'(len_q);
		end
	end

endmodule

/* design/cimask_core.sv */
`timescale 1ns / 1ps
// match window: appends a byte, compares against the pattern, emits the oldest byte
// depends on cimask_pkg
module cimask_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cimask_pkg::cfg_t              cfg,
	input  cimask_pkg::core_ctrl_t        ctrl,
	input  logic [cimask_pkg::CHAR_W-1:0] in_char,
	input  logic                          in_last,
	output cimask_pkg::emit_t             emit,
	output logic                          active
);

	logic [cimask_pkg::CHAR_W-1:0]      bytes_q [cimask_pkg::PATTERN_MAX];
	logic [cimask_pkg::PATTERN_MAX-1:0] masked_q;
	logic [cimask_pkg::FILL_W-1:0]      fill_q;
	logic [cimask_pkg::FILL_W-1:0]      blocked_q;
	logic                               last_q;
	logic                               active_q;

	logic [cimask_pkg::CHAR_W-1:0]      src_bytes [cimask_pkg::PATTERN_MAX];
	logic [cimask_pkg::PATTERN_MAX-1:0] src_masked;
	logic [cimask_pkg::FILL_W-1:0]      src_fill;
	logic                               src_last;
	logic [cimask_pkg::FILL_W-1:0]      need;
	logic [cimask_pkg::PATTERN_MAX-1:0] len_mask;
	logic [cimask_pkg::PATTERN_MAX-1:0] pos_eq;
	logic                               hit;
	logic                               go;
	logic                               emit_ok;
	logic [cimask_pkg::PATTERN_MAX-1:0] hit_masked;
	logic [cimask_pkg::FILL_W-1:0]      hit_blocked;
	logic [cimask_pkg::FILL_W-1:0]      fill_nxt;

	// window as seen this cycle, with the new word appended on accept
	always_comb begin
		src_bytes  = bytes_q;
		src_masked = masked_q;
		src_fill   = fill_q;
		src_last   = last_q;
		if (ctrl.accept) begin
			src_bytes[fill_q[cimask_pkg::IDX_W-1:0]]  = in_char;
			src_masked[fill_q[cimask_pkg::IDX_W-1:0]] = 1'b0;
			src_fill = fill_q + 1'b1;
			src_last = in_last;
		end
	end

	assign need = (cfg.length == '0) ? cimask_pkg::FILL_W'(1) : cfg.length;

	always_comb begin
		for (int k = 0; k < cimask_pkg::PATTERN_MAX; k++) begin
			len_mask[k] = (cimask_pkg::FILL_W'(k) < cfg.length);
			pos_eq[k]   = !len_mask[k] ||
				(cimask_pkg::fold_case(src_bytes[k]) ==
				 cimask_pkg::fold_case(cfg.pattern[k]));
		end
	end

	assign hit = (cfg.length != '0) && (blocked_q == '0) &&
		(src_fill >= cfg.length) && (&pos_eq);
	assign go = ctrl.accept || (active_q && ctrl.advance);
	assign emit_ok = go && ((src_fill >= need) || (src_last && src_fill != '0));
	assign hit_masked  = hit ? (src_masked | len_mask) : src_masked;
	assign hit_blocked = hit ? cfg.length : blocked_q;
	assign fill_nxt    = src_fill - 1'b1;

	always_comb begin
		emit.valid = emit_ok;
		emit.data  = hit_masked[0] ? cfg.mask : src_bytes[0];
		emit.last  = src_last && (src_fill == cimask_pkg::FILL_W'(1));
	end

	assign active = active_q;

	// window bytes carry no reset; only entries below the fill count are read
	always_ff @(posedge clk) begin
		if (emit_ok) begin
			for (int k = 0; k < cimask_pkg::PATTERN_MAX - 1; k++) begin
				bytes_q[k] <= src_bytes[k+1];
			end
			bytes_q[cimask_pkg::PATTERN_MAX-1] <= src_bytes[cimask_pkg::PATTERN_MAX-1];
		end else if (go) begin
			bytes_q <= src_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			masked_q  <= '0;
			fill_q    <= '0;
			blocked_q <= '0;
			last_q    <= 1'b0;
			active_q  <= 1'b0;
		end else if (emit_ok) begin
			masked_q <= {1'b0, hit_masked[cimask_pkg::PATTERN_MAX-1:1]};
			fill_q   <= fill_nxt;
			if (src_last && fill_nxt == '0) begin
				blocked_q <= '0;
			end else if (hit_blocked != '0) begin
				blocked_q <= hit_blocked - 1'b1;
			end else begin
				blocked_q <= hit_blocked;
			end
			last_q   <= src_last && (fill_nxt != '0);
			active_q <= (fill_nxt >= need) || (src_last && fill_nxt != '0);
		end else if (go) begin
			masked_q <= src_masked;
			fill_q   <= src_fill;
			last_q   <= 1'b0;
			active_q <= 1'b0;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < cimask_pkg::FILL_W'(cimask_pkg::PATTERN_MAX))
		else $error("window fill past its depth");

	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid && emit.last |=> fill_q == '0 && blocked_q == '0 && !active_q)
		else $error("window not empty after the final word");

	a_active_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> fill_q != '0)
		else $error("pending drain with an empty window");

	a_no_accept_draining: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> !ctrl.accept)
		else $error("word accepted during a drain");

endmodule

/* design/case_insensitive_pattern_masker.sv */
`timescale 1ns / 1ps
// top level of the case-insensitive pattern masker: handshakes and output register
// depends on cimask_pkg, cimask_cfg and cimask_core
//
// Input words (text_char, text_last) enter on text_valid with text_stall low.
// Each word goes into a window one pattern long; when the window is full the
// oldest byte leaves on the output channel (out_char, out_last), replaced by
// mask_char when it lies inside a match. Matching folds A-Z to lower case and
// resumes just past a match, so matches never overlap.
// Latency: a result is registered at the edge that accepts the word releasing
// it and is offered on the output channel in the next cycle.
// Throughput: one word per cycle in steady state; the first length-1 words of
// a text produce nothing. A word with text_last releases the rest of the
// window, one byte per cycle, up to the pattern length, with text_stall high
// until the last byte (out_last set) is loaded. After the pattern length is
// lowered, the next word likewise drains the surplus bytes one per cycle.
// A pattern length of zero passes each byte straight through.
// While a waiting output word sees out_stall high it holds and text_stall is raised.
// Reset empties the window, sets pattern length 0, pattern bytes 0 and the
// mask byte to '*'. Registers are written through the apb-style port at 8*i
// and must only be changed while the block is idle.
module case_insensitive_pattern_masker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cimask_pkg::ADDR_W-1:0]       paddr,
	input  logic [cimask_pkg::DATA_W-1:0]       pwdata,
	output logic [cimask_pkg::DATA_W-1:0]       prdata,
	output logic                                pready,
	input  logic                                text_valid,
	output logic                                text_stall,
	input  logic [cimask_pkg::CHAR_W-1:0]       text_char,
	input  logic                                text_last,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [cimask_pkg::CHAR_W-1:0]       out_char,
	output logic                                out_last
);

	cimask_pkg::cfg_t       cfg;
	cimask_pkg::core_ctrl_t ctrl;
	cimask_pkg::emit_t      emit;
	logic                   active;
	logic                   out_valid_q;
	logic [cimask_pkg::CHAR_W-1:0] out_char_q;
	logic                   out_last_q;

	cimask_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// output register free or being taken this cycle
	assign ctrl.advance = !out_valid_q || !out_stall;
	assign text_stall   = active || !ctrl.advance;
	assign ctrl.accept  = text_valid && !text_stall;

	cimask_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.ctrl    (ctrl),
		.in_char (text_char),
		.in_last (text_last),
		.emit    (emit),
		.active  (active)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			out_char_q <= emit.data;
			out_last_q <= emit.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

endmodule

/* tb/case_insensitive_pattern_masker_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for the case-insensitive pattern masker
// depends on cimask_pkg and case_insensitive_pattern_masker; predicts every output word
module case_insensitive_pattern_masker_tb;

	localparam int STALL_LIMIT = 1000;
	localparam logic [cimask_pkg::CHAR_W-1:0] LOWER_Z  = 8'h7A;
	localparam logic [cimask_pkg::CHAR_W-1:0] CASE_BIT = 8'h20;

	typedef struct packed {
		logic [cimask_pkg::CHAR_W-1:0] ch;
		logic                          last;
	} out_word_t;

	logic                              clk;
	logic                              arst_n;
	logic                              psel;
	logic                              penable;
	logic                              pwrite;
	logic [cimask_pkg::ADDR_W-1:0]     paddr;
	logic [cimask_pkg::DATA_W-1:0]     pwdata;
	logic [cimask_pkg::DATA_W-1:0]     prdata;
	logic                              pready;
	logic                              text_valid;
	logic                              text_stall;
	logic [cimask_pkg::CHAR_W-1:0]     text_char;
	logic                              text_last;
	logic                              out_valid;
	logic                              out_stall;
	logic [cimask_pkg::CHAR_W-1:0]     out_char;
	logic                              out_last;

	// shadow of the register file and of the byte window
	logic [63:0]                       pat_low = '0;
	logic [63:0]                       pat_high = '0;
	logic [4:0]                        pat_len = '0;
	logic [cimask_pkg::CHAR_W-1:0]     mask_byte = cimask_pkg::MASK_RESET;
	logic [cimask_pkg::CHAR_W-1:0]     held_char [cimask_pkg::PATTERN_MAX];
	logic                              held_masked [cimask_pkg::PATTERN_MAX];
	int                                held_count = 0;
	int                                skip_starts = 0;

	out_word_t          pending_words[$];
	int                 mismatches = 0;
	int                 idle_cycles = 0;
	int                 long_hold_cycles = 0;
	bit                 sender_gaps = 1'b1;
	bit                 out_stall_bursts = 1'b1;

	case_insensitive_pattern_masker DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text_char(text_char),
		.text_last(text_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char(out_char),
		.out_last(out_last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [cimask_pkg::CHAR_W-1:0] lower_ascii(
			input logic [cimask_pkg::CHAR_W-1:0] c);
		if (c >= cimask_pkg::CHAR_UPPER_A && c <= cimask_pkg::CHAR_UPPER_Z) begin
			return c | CASE_BIT;
		end
		return c;
	endfunction

	function automatic bit is_letter(input logic [cimask_pkg::CHAR_W-1:0] c);
		return (c >= cimask_pkg::CHAR_UPPER_A && c <= cimask_pkg::CHAR_UPPER_Z) ||
			(c >= cimask_pkg::CHAR_LOWER_A && c <= LOWER_Z);
	endfunction

	function automatic logic [cimask_pkg::CHAR_W-1:0] pattern_char(input int k);
		if (k < 8) begin
			return pat_low[8*k +: 8];
		end
		return pat_high[8*(k-8) +: 8];
	endfunction

	function automatic int active_len();
		return (pat_len > cimask_pkg::PATTERN_MAX) ? cimask_pkg::PATTERN_MAX : int'(pat_len);
	endfunction

	function automatic void release_oldest(input logic last_flag);
		out_word_t w;
		int k;
		w.ch = held_masked[0] ? mask_byte : held_char[0];
		w.last = last_flag;
		pending_words.push_back(w);
		for (k = 0; k < cimask_pkg::PATTERN_MAX - 1; k++) begin
			held_char[k] = held_char[k+1];
			held_masked[k] = held_masked[k+1];
		end
		held_char[cimask_pkg::PATTERN_MAX-1] = '0;
		held_masked[cimask_pkg::PATTERN_MAX-1] = 1'b0;
		held_count--;
		if (skip_starts > 0) begin
			skip_starts--;
		end
	endfunction

	// works out the output words released by one accepted input word
	function automatic void predict_word(input logic [cimask_pkg::CHAR_W-1:0] c,
			input logic last);
		int len;
		int need;
		int k;
		bit hit;
		len = active_len();
		need = (len > 0) ? len : 1;
		held_char[held_count] = c;
		held_masked[held_count] = 1'b0;
		held_count++;
		while (held_count >= need) begin
			if (len > 0 && skip_starts == 0) begin
				hit = 1'b1;
				for (k = 0; k < len; k++) begin
					if (lower_ascii(held_char[k]) != lower_ascii(pattern_char(k))) begin
						hit = 1'b0;
					end
				end
				if (hit) begin
					for (k = 0; k < len; k++) begin
						held_masked[k] = 1'b1;
					end
					skip_starts = len;
				end
			end
			release_oldest(last && held_count == 1);
		end
		// a match must end inside the text, so the tail leaves unmatched
		if (last) begin
			while (held_count > 0) begin
				release_oldest(held_count == 1);
			end
			for (k = 0; k < cimask_pkg::PATTERN_MAX; k++) begin
				held_masked[k] = 1'b0;
			end
			skip_starts = 0;
		end
	endfunction

	function automatic void note_mismatch(input string what, input out_word_t want,
			input logic [cimask_pkg::CHAR_W-1:0] got_char, input logic got_last);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t mismatch (%s): expected char %02h last %0b, got char %02h last %0b",
				$realtime, what, want.ch, want.last, got_char, got_last);
		end
	endfunction

	// output checker
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				want = '0;
				note_mismatch("no word pending", want, out_char, out_last);
			end else begin
				want = pending_words.pop_front();
				if (out_char !== want.ch || out_last !== want.last) begin
					note_mismatch("wrong word", want, out_char, out_last);
				end
			end
		end
	end

	// receiver stall: random bursts, or one long hold when requested
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (long_hold_cycles) @(posedge clk);
				long_hold_cycles = 0;
				out_stall <= 1'b0;
			end else if (out_stall_bursts && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles in which neither channel moves a word
	initial begin
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((text_valid && !text_stall) || (out_valid && !out_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("case_insensitive_pattern_masker_tb NOT OK");
		$finish;
	end

	task automatic write_reg(input logic [cimask_pkg::REG_IDX_W-1:0] idx,
			input logic [cimask_pkg::DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			cimask_pkg::REG_PATTERN_LOW: begin
				pat_low = value;
			end
			cimask_pkg::REG_PATTERN_HIGH: begin
				pat_high = value;
			end
			cimask_pkg::REG_PATTERN_LEN: begin
				pat_len = value[4:0];
			end
			cimask_pkg::REG_MASK_CHAR: begin
				mask_byte = value[cimask_pkg::CHAR_W-1:0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic send_word(input logic [cimask_pkg::CHAR_W-1:0] c, input logic last);
		if (sender_gaps && $urandom_range(0, 7) == 0) begin
			text_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		text_char <= c;
		text_last <= last;
		text_valid <= 1'b1;
		do @(posedge clk); while (text_stall);
		predict_word(c, last);
	endtask

	// stop sending and wait for every pending word, then let the block settle
	task automatic drain_block();
		text_valid <= 1'b0;
		while (pending_words.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_string(input string s, input bit close_text);
		int i;
		for (i = 0; i < s.len(); i++) begin
			send_word(s[i], close_text && i == s.len() - 1);
		end
	endtask

	task automatic load_pattern(input string s, input logic [cimask_pkg::CHAR_W-1:0] mask);
		logic [127:0] pat_bits;
		int i;
		pat_bits = '0;
		for (i = 0; i < s.len(); i++) begin
			pat_bits[8*i +: 8] = s[i];
		end
		write_reg(cimask_pkg::REG_PATTERN_LOW, pat_bits[63:0]);
		write_reg(cimask_pkg::REG_PATTERN_HIGH, pat_bits[127:64]);
		write_reg(cimask_pkg::REG_PATTERN_LEN, cimask_pkg::DATA_W'(s.len()));
		write_reg(cimask_pkg::REG_MASK_CHAR, cimask_pkg::DATA_W'(mask));
	endtask

	function automatic logic [cimask_pkg::CHAR_W-1:0] random_letter();
		logic [cimask_pkg::CHAR_W-1:0] base;
		base = $urandom_range(0, 1) ? cimask_pkg::CHAR_UPPER_A : cimask_pkg::CHAR_LOWER_A;
		return base + 8'($urandom_range(0, 25));
	endfunction

	task automatic load_random_pattern(input logic [4:0] len_value,
			input logic [cimask_pkg::CHAR_W-1:0] mask);
		logic [127:0] pat_bits;
		int i;
		for (i = 0; i < cimask_pkg::PATTERN_MAX; i++) begin
			pat_bits[8*i +: 8] = ($urandom_range(0, 9) < 7) ? random_letter() :
				8'($urandom_range(0, 255));
		end
		write_reg(cimask_pkg::REG_PATTERN_LOW, pat_bits[63:0]);
		write_reg(cimask_pkg::REG_PATTERN_HIGH, pat_bits[127:64]);
		write_reg(cimask_pkg::REG_PATTERN_LEN, cimask_pkg::DATA_W'(len_value));
		write_reg(cimask_pkg::REG_MASK_CHAR, cimask_pkg::DATA_W'(mask));
	endtask

	// one text built mostly from copies of the pattern with random case
	task automatic send_random_text(input int max_words, output int words);
		logic [cimask_pkg::CHAR_W-1:0] txt[$];
		logic [cimask_pkg::CHAR_W-1:0] b;
		int goal;
		int len;
		int kind;
		int part;
		int k;
		len = active_len();
		goal = $urandom_range(1, max_words);
		while (txt.size() < goal) begin
			kind = $urandom_range(0, 9);
			part = 0;
			if (len > 0 && kind < 5) begin
				part = len;
			end else if (len > 1 && kind < 7) begin
				part = $urandom_range(1, len - 1);
			end
			for (k = 0; k < part; k++) begin
				b = pattern_char(k);
				if (is_letter(b) && $urandom_range(0, 1)) begin
					b = b ^ CASE_BIT;
				end
				txt.push_back(b);
			end
			if (part == 0) begin
				txt.push_back((kind < 9) ? random_letter() : 8'($urandom_range(0, 255)));
			end
		end
		for (k = 0; k < txt.size(); k++) begin
			send_word(txt[k], k == txt.size() - 1);
		end
		words = txt.size();
	endtask

	task automatic send_random_words(input int total, input int max_words);
		int sent;
		int n;
		sent = 0;
		while (sent < total) begin
			send_random_text(max_words, n);
			sent += n;
		end
	endtask

	// reset values: no pattern, every byte goes straight through
	task automatic test_passthrough();
		drain_block();
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h41, 1'b1);
		send_word(8'h5A, 1'b1);
	endtask

	// only A-Z fold: '{' must not match '[', and a trailing partial match stays
	task automatic test_case_folding();
		drain_block();
		load_pattern("Ab[", cimask_pkg::MASK_RESET);
		send_string("aB[xab{AB", 1'b1);
	endtask

	// matches never overlap: "aaa" against "aa" masks only the first two
	task automatic test_no_overlap();
		drain_block();
		load_pattern("aa", 8'h00);
		send_string("aaa", 1'b1);
	endtask

	// length lowered while bytes are held: the surplus leaves on the next word
	task automatic test_length_change();
		drain_block();
		load_pattern("abcd", 8'hFF);
		send_string("xyzab", 1'b0);
		drain_block();
		write_reg(cimask_pkg::REG_PATTERN_LEN, cimask_pkg::DATA_W'(2));
		send_string("cab", 1'b1);
	endtask

	task automatic test_random_configs();
		logic [4:0] lens [7];
		logic [cimask_pkg::CHAR_W-1:0] masks [7];
		int p;
		lens = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd3, 5'd8, 5'd5};
		masks = '{8'h2A, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h2A, 8'h7F};
		for (p = 0; p < 7; p++) begin
			drain_block();
			load_random_pattern(lens[p],
				$urandom_range(0, 1) ? masks[p] : 8'($urandom_range(0, 255)));
			send_random_words(16, (active_len() > 8) ? 40 : 16);
		end
	endtask

	// long receiver hold while words keep coming: the block fills and stalls its input
	task automatic test_backpressure();
		drain_block();
		load_random_pattern(5'd4, 8'($urandom_range(0, 255)));
		sender_gaps = 1'b0;
		long_hold_cycles = 150;
		send_random_words(30, 20);
		sender_gaps = 1'b1;
	endtask

	task automatic test_steady_stream();
		drain_block();
		sender_gaps = 1'b0;
		out_stall_bursts = 1'b0;
		load_random_pattern(5'd2, 8'($urandom_range(0, 255)));
		send_random_words(30, 12);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		text_valid = 1'b0;
		text_char = '0;
		text_last = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_passthrough();
		test_case_folding();
		test_no_overlap();
		test_length_change();
		test_random_configs();
		test_backpressure();
		test_steady_stream();

		text_valid <= 1'b0;
		while (pending_words.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_words.size() == 0) begin
			$display("case_insensitive_pattern_masker_tb OK");
		end else begin
			$display("case_insensitive_pattern_masker_tb NOT OK");
		end
		$finish;
	end

endmodule
